// ===== sv/dpfr_pkg.sv =====
// Shared types, widths and constants of the decimated PI force regulator.
package dpfr_pkg;

  localparam int FORCE_W   = 24;
  localparam int GAIN_W    = 32;
  localparam int VOLT_W    = 16;
  localparam int PHASE_W   = 4;
  localparam int SUM_W     = 40;
  localparam int ERR_W     = FORCE_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DEFAULT_UPDATE_INTERVAL = 10;

  localparam logic signed [VOLT_W-1:0] CEILING_RESET = 16'sd13517;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE_TARGET  = 3'd0,
    CFG_PROP_GAIN     = 3'd1,
    CFG_INTEG_GAIN_DT = 3'd2,
    CFG_BIAS_VOLTAGE  = 3'd3,
    CFG_VOLT_FLOOR    = 3'd4,
    CFG_VOLT_CEILING  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_target;
    logic signed [GAIN_W-1:0]  prop_gain;
    logic signed [GAIN_W-1:0]  integ_gain_dt;
    logic signed [VOLT_W-1:0]  bias_voltage;
    logic signed [VOLT_W-1:0]  voltage_floor;
    logic signed [VOLT_W-1:0]  voltage_ceiling;
  } cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  error_sum;
    logic signed [VOLT_W-1:0] held_voltage;
    logic [PHASE_W-1:0]       phase_count;
  } state_t;

  typedef struct packed {
    state_t                   next_state;
    logic signed [VOLT_W-1:0] drive_voltage;
    logic                     updated;
    logic                     fault;
    logic [PHASE_W-1:0]       tick_phase;
  } calc_res_t;

endpackage

// ===== sv/dpfr_calc.sv =====
// One tick of the regulator: phase step, error integration, PI sum, saturation and clamp.
module dpfr_calc import dpfr_pkg::*; #(
  parameter int UPDATE_INTERVAL = DEFAULT_UPDATE_INTERVAL
) (
  input  cfg_t                      cfg,
  input  state_t                    state,
  input  logic                      restart,
  input  logic                      sensor_ok,
  input  logic signed [FORCE_W-1:0] force_meas,
  output calc_res_t                 res
);

  localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};
  localparam logic signed [58:0]    ROUND_HALF = 59'sd8388608;
  localparam logic signed [49:0]    V_MAX = 50'sd32767;
  localparam logic signed [49:0]    V_MIN = -50'sd32768;

  state_t                   base;
  logic [PHASE_W-1:0]       phase_inc;
  logic                     do_update;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_new;
  logic signed [15:0]       sum_hi;
  logic signed [24:0]       sum_lo;
  logic signed [56:0]       prod_p;
  logic signed [56:0]       prod_il;
  logic signed [47:0]       prod_ih;
  logic signed [58:0]       frac;
  logic signed [48:0]       whole;
  logic signed [49:0]       v_raw;
  logic signed [VOLT_W-1:0] v_sat;
  logic signed [VOLT_W-1:0] v_clamp;

  always_comb begin
    base = restart ? '0 : state;
    phase_inc = base.phase_count + 1'b1;
    do_update = (phase_inc >= PHASE_W'(UPDATE_INTERVAL));

    err = ERR_W'(cfg.force_target) - ERR_W'(force_meas);
    sum_wide = (SUM_W+1)'(base.error_sum) + (SUM_W+1)'(err);
    if (sum_wide > SUM_MAX) begin
      sum_new = SUM_MAX[SUM_W-1:0];
    end else if (sum_wide < SUM_MIN) begin
      sum_new = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_new = sum_wide[SUM_W-1:0];
    end

    // split the sum so both integral products stay under 32x25
    sum_hi = sum_new[SUM_W-1:24];
    sum_lo = {1'b0, sum_new[23:0]};
    prod_p  = 57'(cfg.prop_gain) * 57'(err);
    prod_il = 57'(cfg.integ_gain_dt) * 57'(sum_lo);
    prod_ih = 48'(cfg.integ_gain_dt) * 48'(sum_hi);

    frac  = 59'(prod_p) + 59'(prod_il) + ROUND_HALF;
    whole = 49'(prod_ih) + 49'(cfg.bias_voltage);
    v_raw = 50'(whole) + 50'($signed(frac[58:24]));

    if (v_raw > V_MAX) begin
      v_sat = V_MAX[VOLT_W-1:0];
    end else if (v_raw < V_MIN) begin
      v_sat = V_MIN[VOLT_W-1:0];
    end else begin
      v_sat = v_raw[VOLT_W-1:0];
    end
    // floor first, ceiling last: ceiling wins when they cross
    v_clamp = (v_sat < cfg.voltage_floor) ? cfg.voltage_floor : v_sat;
    if (v_clamp > cfg.voltage_ceiling) begin
      v_clamp = cfg.voltage_ceiling;
    end

    res = '0;
    if (!sensor_ok) begin
      res.fault = 1'b1;
    end else if (do_update) begin
      res.next_state.error_sum    = sum_new;
      res.next_state.held_voltage = v_clamp;
      res.next_state.phase_count  = '0;
      res.drive_voltage           = v_clamp;
      res.updated                 = 1'b1;
      res.tick_phase              = '0;
    end else begin
      res.next_state.error_sum    = base.error_sum;
      res.next_state.held_voltage = base.held_voltage;
      res.next_state.phase_count  = phase_inc;
      res.drive_voltage           = base.held_voltage;
      res.tick_phase              = phase_inc;
    end
  end

endmodule

// ===== sv/decimated_pi_force_regulator.sv =====
// A word taken into the input register reaches the outputs when it moves into the result register.
// Throughput: one word per cycle while out_ready is high; the input register and the result register form
// a two-stage pipe and the regulator state is updated as a word moves into the result.
// Reset (rst, synchronous): pipe empty, state zero, configuration registers at their defaults.
// Configuration writes are taken every cycle (cfg_ready is always high).
module decimated_pi_force_regulator import dpfr_pkg::*; #(
  parameter int UPDATE_INTERVAL = DEFAULT_UPDATE_INTERVAL
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         restart,
  input  logic                         sensor_ok,
  input  logic signed [FORCE_W-1:0]    force_meas,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VOLT_W-1:0]     drive_voltage,
  output logic                         updated,
  output logic                         fault,
  output logic [PHASE_W-1:0]           tick_phase
);

  cfg_t      cfg;
  state_t    state;
  calc_res_t res;

  logic                      s1_valid;
  logic                      s1_restart;
  logic                      s1_sensor_ok;
  logic signed [FORCE_W-1:0] s1_force;
  logic                      advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.force_target    <= '0;
      cfg.prop_gain       <= '0;
      cfg.integ_gain_dt   <= '0;
      cfg.bias_voltage    <= '0;
      cfg.voltage_floor   <= '0;
      cfg.voltage_ceiling <= CEILING_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FORCE_TARGET:  cfg.force_target    <= cfg_data[FORCE_W-1:0];
        CFG_PROP_GAIN:     cfg.prop_gain       <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN_DT: cfg.integ_gain_dt   <= cfg_data[GAIN_W-1:0];
        CFG_BIAS_VOLTAGE:  cfg.bias_voltage    <= cfg_data[VOLT_W-1:0];
        CFG_VOLT_FLOOR:    cfg.voltage_floor   <= cfg_data[VOLT_W-1:0];
        CFG_VOLT_CEILING:  cfg.voltage_ceiling <= cfg_data[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  dpfr_calc #(
    .UPDATE_INTERVAL(UPDATE_INTERVAL)
  ) u_calc (
    .cfg        (cfg),
    .state      (state),
    .restart    (s1_restart),
    .sensor_ok  (s1_sensor_ok),
    .force_meas (s1_force),
    .res        (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_restart   <= restart;
      s1_sensor_ok <= sensor_ok;
      s1_force     <= force_meas;
    end
  end

  // regulator state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state     <= res.next_state;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      drive_voltage <= res.drive_voltage;
      updated       <= res.updated;
      fault         <= res.fault;
      tick_phase    <= res.tick_phase;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tick_phase < PHASE_W'(UPDATE_INTERVAL)))
    else $error("tick_phase out of range");

  a_fault_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault) |-> (drive_voltage == '0 && !updated && tick_phase == '0))
    else $error("fault word not cleared");

  a_update_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && updated) |-> (tick_phase == '0 && !fault))
    else $error("update word with nonzero phase");

  a_update_ceiling: assert property (@(posedge clk) disable iff (rst)
    (advance && res.updated) |=> (drive_voltage <= $past(cfg.voltage_ceiling)))
    else $error("updated voltage above ceiling");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without a word moving");

endmodule
